/* sv/thp_pkg.sv */
`default_nettype none

package thp_pkg;

  localparam int GAIN_W      = 24;
  localparam int LIMIT_W     = 20;
  localparam int BAND_W      = 15;
  localparam int TICKS_W     = 8;
  localparam int DRIVE_LIM_W = 14;
  localparam int HEADING_W   = 16;
  localparam int TIMEOUT_W   = 16;
  localparam int DRIVE_W     = 15;
  localparam int ERR_W       = 16;
  localparam int DELTA_W     = 17;
  localparam int SUM_W       = 21;
  localparam int PROD_W      = 47;
  localparam int FRAC_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic signed [17:0] HALF_TURN = 18'sd18000;
  localparam logic signed [17:0] FULL_TURN = 18'sd36000;

  localparam logic [GAIN_W-1:0]      PROP_GAIN_RST      = 24'd131072;
  localparam logic [GAIN_W-1:0]      INTEG_GAIN_RST     = 24'd66;
  localparam logic [GAIN_W-1:0]      DERIV_GAIN_RST     = 24'd983040;
  localparam logic [LIMIT_W-1:0]     INTEGRAL_LIMIT_RST = 20'd100000;
  localparam logic [BAND_W-1:0]      SETTLE_BAND_RST    = 15'd50;
  localparam logic [TICKS_W-1:0]     SETTLE_TICKS_RST   = 8'd10;
  localparam logic [DRIVE_LIM_W-1:0] DRIVE_LIMIT_RST    = 14'd12000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PROP_GAIN      = 3'd0,
    CFG_INTEG_GAIN     = 3'd1,
    CFG_DERIV_GAIN     = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_SETTLE_BAND    = 3'd4,
    CFG_SETTLE_TICKS   = 3'd5,
    CFG_DRIVE_LIMIT    = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_IDLE    = 2'd0,
    STATUS_RUNNING = 2'd1,
    STATUS_SETTLED = 2'd2,
    STATUS_TIMEOUT = 2'd3
  } status_t;

  // Per-item work handed from the state stage to the drive pipeline.
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;
    logic                      use_drive;
    status_t                   status;
  } work_t;

  typedef struct packed {
    logic [GAIN_W-1:0]      prop_gain;
    logic [GAIN_W-1:0]      integ_gain;
    logic [GAIN_W-1:0]      deriv_gain;
    logic [DRIVE_LIM_W-1:0] drive_limit;
  } gains_t;

endpackage

`default_nettype wire

/* sv/thp_cmd_if.sv */
`default_nettype none

interface thp_cmd_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [thp_pkg::HEADING_W-1:0]  target_heading;
  logic [thp_pkg::TIMEOUT_W-1:0]  timeout_ticks;
  logic [thp_pkg::HEADING_W-1:0]  measured_heading;

  modport source (output valid, func, target_heading, timeout_ticks, measured_heading,
                  input ready);
  modport sink   (input valid, func, target_heading, timeout_ticks, measured_heading,
                  output ready);
endinterface

`default_nettype wire

/* sv/thp_rsp_if.sv */
`default_nettype none

interface thp_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [thp_pkg::DRIVE_W-1:0] left_drive_mv;
  logic signed [thp_pkg::DRIVE_W-1:0] right_drive_mv;
  logic [1:0]                         move_status;

  modport source (output valid, left_drive_mv, right_drive_mv, move_status, input ready);
  modport sink   (input valid, left_drive_mv, right_drive_mv, move_status, output ready);
endinterface

`default_nettype wire

/* sv/thp_cfg_if.sv */
`default_nettype none

interface thp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [thp_pkg::CFG_INDEX_W-1:0]  index;
  logic [thp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/thp_drive_pipe.sv */
`default_nettype none

module thp_drive_pipe (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           work_valid,
  output logic                work_ready,
  input  wire thp_pkg::work_t work,
  input  wire thp_pkg::gains_t gains,
  thp_rsp_if.source           rsp
);

  localparam logic signed [thp_pkg::PROD_W-1:0] ROUND_UP   = 47'sd32768;
  localparam logic signed [thp_pkg::PROD_W-1:0] ROUND_DOWN = 47'sd32767;

  // Stage 3: the three gain products.
  logic                                 v3;
  logic signed [thp_pkg::PROD_W-1:0]    prod_p;
  logic signed [thp_pkg::PROD_W-1:0]    prod_i;
  logic signed [thp_pkg::PROD_W-1:0]    prod_d;
  logic                                 use3;
  thp_pkg::status_t                     status3;

  // Stage 4: the summed command before scaling.
  logic                                 v4;
  logic signed [thp_pkg::PROD_W-1:0]    psum;
  logic                                 use4;
  thp_pkg::status_t                     status4;

  // Result register.
  logic                                 out_v;
  logic signed [thp_pkg::DRIVE_W-1:0]   left_q;
  logic signed [thp_pkg::DRIVE_W-1:0]   right_q;
  thp_pkg::status_t                     status_q;

  logic ld_out, ld4, ld3;

  logic signed [thp_pkg::PROD_W-1:0]    rounded;
  logic signed [thp_pkg::PROD_W-1:0]    lim_wide;
  logic signed [thp_pkg::PROD_W-1:0]    sat;
  logic signed [thp_pkg::DRIVE_W-1:0]   drive;

  assign ld_out     = !out_v || rsp.ready;
  assign ld4        = !v4 || ld_out;
  assign ld3        = !v3 || ld4;
  assign work_ready = ld3;

  // Round to nearest with ties away from zero: a negative sum takes one less bias.
  always_comb begin
    rounded  = (psum + (psum[thp_pkg::PROD_W-1] ? ROUND_DOWN : ROUND_UP)) >>> thp_pkg::FRAC_W;
    lim_wide = $signed({{(thp_pkg::PROD_W-thp_pkg::DRIVE_LIM_W){1'b0}}, gains.drive_limit});
    if (rounded > lim_wide) begin
      sat = lim_wide;
    end else if (rounded < -lim_wide) begin
      sat = -lim_wide;
    end else begin
      sat = rounded;
    end
    drive = sat[thp_pkg::DRIVE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3    <= 1'b0;
      v4    <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (ld3) begin
        v3 <= work_valid;
      end
      if (ld4) begin
        v4 <= v3;
      end
      if (ld_out) begin
        out_v <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      prod_p  <= $signed({1'b0, gains.prop_gain}) * $signed(work.err);
      prod_d  <= $signed({1'b0, gains.deriv_gain}) * $signed(work.delta);
      prod_i  <= $signed({1'b0, gains.integ_gain}) * $signed(work.sum);
      use3    <= work.use_drive;
      status3 <= work.status;
    end
    if (ld4) begin
      psum    <= prod_p + prod_d + prod_i;
      use4    <= use3;
      status4 <= status3;
    end
    if (ld_out) begin
      left_q   <= use4 ? drive : '0;
      right_q  <= use4 ? -drive : '0;
      status_q <= status4;
    end
  end

  assign rsp.valid          = out_v;
  assign rsp.left_drive_mv  = left_q;
  assign rsp.right_drive_mv = right_q;
  assign rsp.move_status    = status_q;

  logic signed [thp_pkg::DRIVE_W:0] left_wide;
  logic signed [thp_pkg::DRIVE_W:0] lim_out;
  assign left_wide = {rsp.left_drive_mv[thp_pkg::DRIVE_W-1], rsp.left_drive_mv};
  assign lim_out   = $signed({2'b00, gains.drive_limit});

  a_mirror: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.right_drive_mv == -rsp.left_drive_mv)
    else $error("right drive is not the negation of left drive");

  a_zero_when_stopped: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.move_status != thp_pkg::STATUS_RUNNING |-> rsp.left_drive_mv == '0)
    else $error("nonzero drive on a result that is not running");

  a_saturated: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> left_wide <= lim_out && left_wide >= -lim_out)
    else $error("drive outside the saturation limit");

endmodule

`default_nettype wire

/* sv/turn_heading_pid_core.sv */
// An accepted beat passes the input, work, product, sum and result registers.
// Throughput: one item per cycle unless the result side stalls; the heading state is
// updated in a single stage; the gain products, sum and rounding take three stages.
// Reset (rst, synchronous): gains and limits return to their defaults, the move
// goes idle with all heading state cleared, and the pipeline empties.
`default_nettype none

module turn_heading_pid_core (
  input  wire logic clk,
  input  wire logic rst,
  thp_cmd_if.sink   cmd,
  thp_rsp_if.source rsp,
  thp_cfg_if.sink   cfg
);

  // Configuration registers.
  logic [thp_pkg::GAIN_W-1:0]      prop_gain;
  logic [thp_pkg::GAIN_W-1:0]      integ_gain;
  logic [thp_pkg::GAIN_W-1:0]      deriv_gain;
  logic [thp_pkg::LIMIT_W-1:0]     integral_limit;
  logic [thp_pkg::BAND_W-1:0]      settle_band;
  logic [thp_pkg::TICKS_W-1:0]     settle_ticks;
  logic [thp_pkg::DRIVE_LIM_W-1:0] drive_limit;

  // Move state.
  logic                              active;
  logic [thp_pkg::HEADING_W-1:0]     goal_heading;
  logic [thp_pkg::TIMEOUT_W-1:0]     time_limit;
  logic [thp_pkg::TIMEOUT_W-1:0]     elapsed;
  logic signed [thp_pkg::ERR_W-1:0]  last_error;
  logic signed [thp_pkg::SUM_W-1:0]  error_sum;
  logic [thp_pkg::TICKS_W-1:0]       settle_count;

  // Input register.
  logic                              v1;
  logic                              s1_func;
  logic [thp_pkg::HEADING_W-1:0]     s1_target;
  logic [thp_pkg::TIMEOUT_W-1:0]     s1_timeout;
  logic [thp_pkg::HEADING_W-1:0]     s1_measured;

  // Work register toward the drive pipeline.
  logic                              v2;
  thp_pkg::work_t                    work;
  thp_pkg::work_t                    work_next;
  logic                              work_ready;
  thp_pkg::gains_t                   gains;

  logic ld1, ld2, fire;

  logic signed [17:0]                   err_w;
  logic signed [thp_pkg::ERR_W-1:0]     err_new;
  logic signed [thp_pkg::DELTA_W-1:0]   delta_new;
  logic signed [thp_pkg::SUM_W:0]       sum_raw;
  logic signed [thp_pkg::SUM_W:0]       lim_pos;
  logic signed [thp_pkg::SUM_W:0]       sum_clamped;
  logic signed [thp_pkg::SUM_W-1:0]     sum_new;
  logic [thp_pkg::ERR_W-1:0]            err_abs;
  logic                                 in_band;
  logic [thp_pkg::TICKS_W-1:0]          settle_next;
  logic [thp_pkg::TIMEOUT_W-1:0]        elapsed_next;
  logic                                 settled;
  logic                                 is_start;
  logic                                 timed_out;
  logic                                 tick_run;

  assign ld2       = !v2 || work_ready;
  assign ld1       = !v1 || ld2;
  assign fire      = v1 && ld2;
  assign cmd.ready = ld1;
  assign cfg.ready = 1'b1;

  assign gains = '{prop_gain: prop_gain, integ_gain: integ_gain,
                   deriv_gain: deriv_gain, drive_limit: drive_limit};

  // Heading error folded into plus or minus half a turn; two folds cover any 16-bit pair.
  always_comb begin
    err_w = $signed({2'b00, goal_heading}) - $signed({2'b00, s1_measured});
    if (err_w > thp_pkg::HALF_TURN) begin
      err_w = err_w - thp_pkg::FULL_TURN;
    end
    if (err_w > thp_pkg::HALF_TURN) begin
      err_w = err_w - thp_pkg::FULL_TURN;
    end
    if (err_w < -thp_pkg::HALF_TURN) begin
      err_w = err_w + thp_pkg::FULL_TURN;
    end
    if (err_w < -thp_pkg::HALF_TURN) begin
      err_w = err_w + thp_pkg::FULL_TURN;
    end
    err_new = err_w[thp_pkg::ERR_W-1:0];
  end

  always_comb begin
    delta_new = $signed({err_new[thp_pkg::ERR_W-1], err_new})
              - $signed({last_error[thp_pkg::ERR_W-1], last_error});
    sum_raw   = $signed({error_sum[thp_pkg::SUM_W-1], error_sum})
              + $signed({{(thp_pkg::SUM_W+1-thp_pkg::ERR_W){err_new[thp_pkg::ERR_W-1]}},
                         err_new});
    lim_pos   = $signed({2'b00, integral_limit});
    if (sum_raw > lim_pos) begin
      sum_clamped = lim_pos;
    end else if (sum_raw < -lim_pos) begin
      sum_clamped = -lim_pos;
    end else begin
      sum_clamped = sum_raw;
    end
    sum_new = sum_clamped[thp_pkg::SUM_W-1:0];

    err_abs = err_new[thp_pkg::ERR_W-1] ? 16'(-err_new) : err_new;
    in_band = err_abs[thp_pkg::BAND_W-1:0] < settle_band;
    if (!in_band) begin
      settle_next = '0;
    end else if (settle_count != '1) begin
      settle_next = settle_count + 1'b1;
    end else begin
      settle_next = settle_count;
    end
    settled      = settle_next >= settle_ticks;
    elapsed_next = (elapsed != '1) ? elapsed + 1'b1 : elapsed;

    is_start  = s1_func == thp_pkg::FUNC_START;
    timed_out = !is_start && active && elapsed >= time_limit;
    tick_run  = !is_start && active && !timed_out;

    work_next.err       = err_new;
    work_next.delta     = delta_new;
    work_next.sum       = sum_new;
    work_next.use_drive = tick_run && !settled;
    if (is_start) begin
      work_next.status = thp_pkg::STATUS_RUNNING;
    end else if (!active) begin
      work_next.status = thp_pkg::STATUS_IDLE;
    end else if (timed_out) begin
      work_next.status = thp_pkg::STATUS_TIMEOUT;
    end else if (settled) begin
      work_next.status = thp_pkg::STATUS_SETTLED;
    end else begin
      work_next.status = thp_pkg::STATUS_RUNNING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= thp_pkg::PROP_GAIN_RST;
      integ_gain     <= thp_pkg::INTEG_GAIN_RST;
      deriv_gain     <= thp_pkg::DERIV_GAIN_RST;
      integral_limit <= thp_pkg::INTEGRAL_LIMIT_RST;
      settle_band    <= thp_pkg::SETTLE_BAND_RST;
      settle_ticks   <= thp_pkg::SETTLE_TICKS_RST;
      drive_limit    <= thp_pkg::DRIVE_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        thp_pkg::CFG_PROP_GAIN:      prop_gain      <= cfg.data[thp_pkg::GAIN_W-1:0];
        thp_pkg::CFG_INTEG_GAIN:     integ_gain     <= cfg.data[thp_pkg::GAIN_W-1:0];
        thp_pkg::CFG_DERIV_GAIN:     deriv_gain     <= cfg.data[thp_pkg::GAIN_W-1:0];
        thp_pkg::CFG_INTEGRAL_LIMIT: integral_limit <= cfg.data[thp_pkg::LIMIT_W-1:0];
        thp_pkg::CFG_SETTLE_BAND:    settle_band    <= cfg.data[thp_pkg::BAND_W-1:0];
        thp_pkg::CFG_SETTLE_TICKS:   settle_ticks   <= cfg.data[thp_pkg::TICKS_W-1:0];
        thp_pkg::CFG_DRIVE_LIMIT:    drive_limit    <= cfg.data[thp_pkg::DRIVE_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      goal_heading <= '0;
      time_limit   <= '0;
      elapsed      <= '0;
      last_error   <= '0;
      error_sum    <= '0;
      settle_count <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= cmd.valid;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (fire) begin
        if (is_start) begin
          goal_heading <= s1_target;
          time_limit   <= s1_timeout;
          elapsed      <= '0;
          last_error   <= '0;
          error_sum    <= '0;
          settle_count <= '0;
          active       <= 1'b1;
        end else if (timed_out) begin
          active <= 1'b0;
        end else if (tick_run) begin
          last_error   <= err_new;
          error_sum    <= sum_new;
          elapsed      <= elapsed_next;
          settle_count <= settle_next;
          if (settled) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_func     <= cmd.func;
      s1_target   <= cmd.target_heading;
      s1_timeout  <= cmd.timeout_ticks;
      s1_measured <= cmd.measured_heading;
    end
    if (ld2) begin
      work <= work_next;
    end
  end

  thp_drive_pipe u_drive_pipe (
    .clk        (clk),
    .rst        (rst),
    .work_valid (v2),
    .work_ready (work_ready),
    .work       (work),
    .gains      (gains),
    .rsp        (rsp)
  );

  logic signed [thp_pkg::SUM_W:0] sum_wide;
  assign sum_wide = {error_sum[thp_pkg::SUM_W-1], error_sum};

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    fire && is_start |=> active && elapsed == '0 && error_sum == '0)
    else $error("start beat did not arm a fresh move");

  a_sum_clamped: assert property (@(posedge clk) disable iff (rst)
    fire && tick_run |=> sum_wide <= lim_pos && sum_wide >= -lim_pos)
    else $error("error sum escaped its clamp");

  a_timeout_stops: assert property (@(posedge clk) disable iff (rst)
    fire && timed_out |=> !active && $stable(elapsed))
    else $error("timed-out move still active or counting");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int DRAIN_WAIT  = 20;

  // Short names for the codes used in the directed table.
  localparam logic             FN_START   = thp_pkg::FUNC_START;
  localparam logic             FN_TICK    = thp_pkg::FUNC_TICK;
  localparam thp_pkg::status_t ST_IDLE    = thp_pkg::STATUS_IDLE;
  localparam thp_pkg::status_t ST_RUN     = thp_pkg::STATUS_RUNNING;
  localparam thp_pkg::status_t ST_SETTLED = thp_pkg::STATUS_SETTLED;
  localparam thp_pkg::status_t ST_TIMEOUT = thp_pkg::STATUS_TIMEOUT;

  typedef struct packed {
    logic                          func;
    logic [thp_pkg::HEADING_W-1:0] target;
    logic [thp_pkg::TIMEOUT_W-1:0] timeout;
    logic [thp_pkg::HEADING_W-1:0] meas;
  } heading_cmd_t;

  typedef struct packed {
    logic signed [thp_pkg::DRIVE_W-1:0] left;
    logic signed [thp_pkg::DRIVE_W-1:0] right;
    thp_pkg::status_t                   status;
  } drive_result_t;

  typedef struct packed {
    heading_cmd_t  cmd;
    logic          typed;
    drive_result_t res;
  } directed_row_t;

  // Rows with typed = 1 carry their own result; the others use the predictor.
  localparam directed_row_t DIRECTED [25] = '{
    '{'{FN_TICK,  16'd0,     16'd0,     16'd0},     1'b1, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd65535}, 1'b1, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_START, 16'd0,     16'd0,     16'd0},     1'b1, '{15'sd0, 15'sd0, ST_RUN}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd1234},  1'b1, '{15'sd0, 15'sd0, ST_TIMEOUT}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd1234},  1'b1, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_START, 16'd35999, 16'd65535, 16'd0},     1'b1, '{15'sd0, 15'sd0, ST_RUN}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd0},     1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd17999}, 1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd54000}, 1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd65535}, 1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_START, 16'd18000, 16'd100,   16'd0},     1'b1, '{15'sd0, 15'sd0, ST_RUN}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd0},     1'b1,
      '{15'sd12000, -15'sd12000, ST_RUN}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd36000}, 1'b1,
      '{-15'sd12000, 15'sd12000, ST_RUN}},
    '{'{FN_START, 16'd100,   16'd1000,  16'd0},     1'b1, '{15'sd0, 15'sd0, ST_RUN}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd50},    1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd100},   1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd100},   1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd100},   1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd100},   1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd100},   1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd100},   1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd100},   1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd100},   1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd100},   1'b0, '{15'sd0, 15'sd0, ST_IDLE}},
    '{'{FN_TICK,  16'd0,     16'd0,     16'd100},   1'b1, '{15'sd0, 15'sd0, ST_SETTLED}}
  };

  logic clk;
  logic rst;

  thp_cmd_if cmd_bus ();
  thp_rsp_if rsp_bus ();
  thp_cfg_if cfg_bus ();

  turn_heading_pid_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Controller settings as the block should hold them.
  int kp        = thp_pkg::PROP_GAIN_RST;
  int ki        = thp_pkg::INTEG_GAIN_RST;
  int kd        = thp_pkg::DERIV_GAIN_RST;
  int sum_lim   = thp_pkg::INTEGRAL_LIMIT_RST;
  int band      = thp_pkg::SETTLE_BAND_RST;
  int need_in   = thp_pkg::SETTLE_TICKS_RST;
  int drive_max = thp_pkg::DRIVE_LIMIT_RST;

  // Move state as the block should hold it.
  logic move_on    = 1'b0;
  int   goal       = 0;
  int   tick_limit = 0;
  int   ticks_run  = 0;
  int   prev_err   = 0;
  int   err_accum  = 0;
  int   in_band    = 0;

  drive_result_t pending_drives [$];
  int  mismatches    = 0;
  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  int  hold_requests = 0;
  int  hold_served   = 0;
  int  hold_left     = 0;
  int  cycles        = 0;

  function automatic drive_result_t pid_step(input heading_cmd_t c);
    int            err;
    int            delta;
    int            mag;
    int            drive;
    longint        p;
    longint        r;
    drive_result_t res;
    res.left   = '0;
    res.right  = '0;
    res.status = thp_pkg::STATUS_IDLE;
    if (c.func == thp_pkg::FUNC_START) begin
      goal       = int'(c.target);
      tick_limit = int'(c.timeout);
      ticks_run  = 0;
      prev_err   = 0;
      err_accum  = 0;
      in_band    = 0;
      move_on    = 1'b1;
      res.status = thp_pkg::STATUS_RUNNING;
      return res;
    end
    if (!move_on) return res;
    if (ticks_run >= tick_limit) begin
      move_on    = 1'b0;
      res.status = thp_pkg::STATUS_TIMEOUT;
      return res;
    end
    err = goal - int'(c.meas);
    while (err > int'(thp_pkg::HALF_TURN)) err -= int'(thp_pkg::FULL_TURN);
    while (err < -int'(thp_pkg::HALF_TURN)) err += int'(thp_pkg::FULL_TURN);
    delta    = err - prev_err;
    prev_err = err;
    err_accum += err;
    if (err_accum > sum_lim) err_accum = sum_lim;
    if (err_accum < -sum_lim) err_accum = -sum_lim;
    p = longint'(kp) * err + longint'(kd) * delta + longint'(ki) * err_accum;
    // Round half away from zero on the magnitude, then saturate.
    r = ((p < 0 ? -p : p) + 64'sd32768) >>> 16;
    if (r > drive_max) r = drive_max;
    drive = (p < 0) ? -int'(r) : int'(r);
    if (ticks_run < 65535) ticks_run++;
    mag = (err < 0) ? -err : err;
    if (mag < band) begin
      if (in_band < 255) in_band++;
    end else begin
      in_band = 0;
    end
    if (in_band >= need_in) begin
      move_on    = 1'b0;
      res.status = thp_pkg::STATUS_SETTLED;
      return res;
    end
    res.left   = thp_pkg::DRIVE_W'(drive);
    res.right  = thp_pkg::DRIVE_W'(-drive);
    res.status = thp_pkg::STATUS_RUNNING;
    return res;
  endfunction

  task automatic send_cmd(input heading_cmd_t c, input logic typed, input drive_result_t given);
    drive_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid            <= 1'b1;
    cmd_bus.func             <= c.func;
    cmd_bus.target_heading   <= c.target;
    cmd_bus.timeout_ticks    <= c.timeout;
    cmd_bus.measured_heading <= c.meas;
    do @(posedge clk); while (!cmd_bus.ready);
    predicted = pid_step(c);
    pending_drives.push_back(typed ? given : predicted);
  endtask

  task automatic send_random(input heading_cmd_t c);
    drive_result_t none;
    none = '0;
    send_cmd(c, 1'b0, none);
  endtask

  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input thp_pkg::cfg_index_t idx, input int value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= thp_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      thp_pkg::CFG_PROP_GAIN:      kp        = value & 24'hFFFFFF;
      thp_pkg::CFG_INTEG_GAIN:     ki        = value & 24'hFFFFFF;
      thp_pkg::CFG_DERIV_GAIN:     kd        = value & 24'hFFFFFF;
      thp_pkg::CFG_INTEGRAL_LIMIT: sum_lim   = value & 20'hFFFFF;
      thp_pkg::CFG_SETTLE_BAND:    band      = value & 15'h7FFF;
      thp_pkg::CFG_SETTLE_TICKS:   need_in   = value & 8'hFF;
      thp_pkg::CFG_DRIVE_LIMIT:    drive_max = value & 14'h3FFF;
      default: ;
    endcase
  endtask

  task automatic program_regs(input int p_g, input int i_g, input int d_g, input int lim,
                              input int bnd, input int tks, input int dmax);
    write_reg(thp_pkg::CFG_PROP_GAIN, p_g);
    write_reg(thp_pkg::CFG_INTEG_GAIN, i_g);
    write_reg(thp_pkg::CFG_DERIV_GAIN, d_g);
    write_reg(thp_pkg::CFG_INTEGRAL_LIMIT, lim);
    write_reg(thp_pkg::CFG_SETTLE_BAND, bnd);
    write_reg(thp_pkg::CFG_SETTLE_TICKS, tks);
    write_reg(thp_pkg::CFG_DRIVE_LIMIT, dmax);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic int rand_gain();
    return int'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16));
  endfunction

  // A heading near the target, within +/- span, folded back into one turn.
  function automatic logic [thp_pkg::HEADING_W-1:0] heading_near(input int tgt,
                                                                 input int span);
    int h;
    h = tgt - (int'($urandom_range(0, 2 * span)) - span);
    h = ((h % 36000) + 36000) % 36000;
    return thp_pkg::HEADING_W'(h);
  endfunction

  // Mostly whole moves: a start followed by ticks that hover around the target.
  task automatic run_moves(input int count);
    heading_cmd_t c;
    int           sent;
    int           n;
    int           span;
    int           pick;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        c.func    = thp_pkg::FUNC_TICK;
        c.target  = thp_pkg::HEADING_W'($urandom);
        c.timeout = thp_pkg::TIMEOUT_W'($urandom);
        c.meas    = thp_pkg::HEADING_W'($urandom);
        send_random(c);
        sent++;
      end else begin
        c.func    = thp_pkg::FUNC_START;
        c.target  = ($urandom_range(0, 19) == 0) ? thp_pkg::HEADING_W'($urandom)
                    : thp_pkg::HEADING_W'($urandom_range(0, 35999));
        c.timeout = ($urandom_range(0, 3) == 0) ? thp_pkg::TIMEOUT_W'($urandom)
                    : thp_pkg::TIMEOUT_W'($urandom_range(0, 60));
        c.meas    = thp_pkg::HEADING_W'($urandom);
        send_random(c);
        sent++;
        case ($urandom_range(0, 3))
          0:       span = 20;
          1:       span = 100;
          2:       span = 1000;
          default: span = 18000;
        endcase
        n = $urandom_range(1, 40);
        c.func = thp_pkg::FUNC_TICK;
        for (int k = 0; k < n; k++) begin
          pick = $urandom_range(0, 9);
          if (pick < 6)       c.meas = heading_near(int'(c.target), span);
          else if (pick < 8)  c.meas = thp_pkg::HEADING_W'($urandom_range(0, 35999));
          else if (pick == 8) c.meas = thp_pkg::HEADING_W'($urandom);
          else                c.meas = thp_pkg::HEADING_W'(
                                         int'(heading_near(int'(c.target), span))
                                         + 36000 * int'($urandom_range(0, 1)));
          c.timeout = thp_pkg::TIMEOUT_W'($urandom);
          send_random(c);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    drive_result_t want;
    if (rsp_bus.valid && rsp_bus.ready) begin
      if (pending_drives.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: left %0d right %0d status %0d",
                   rsp_bus.left_drive_mv, rsp_bus.right_drive_mv, rsp_bus.move_status);
        mismatches++;
      end else begin
        want = pending_drives.pop_front();
        if (rsp_bus.left_drive_mv !== want.left || rsp_bus.right_drive_mv !== want.right ||
            rsp_bus.move_status !== want.status) begin
          if (mismatches < 10)
            $display("mismatch: expected left %0d right %0d status %0d, got %0d %0d %0d",
                     want.left, want.right, want.status, rsp_bus.left_drive_mv,
                     rsp_bus.right_drive_mv, rsp_bus.move_status);
          mismatches++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL turn_heading_pid_core");
      $finish;
    end
  end

  initial begin
    rst                      <= 1'b1;
    cmd_bus.valid            <= 1'b0;
    cmd_bus.func             <= thp_pkg::FUNC_START;
    cmd_bus.target_heading   <= '0;
    cmd_bus.timeout_ticks    <= '0;
    cmd_bus.measured_heading <= '0;
    cfg_bus.valid            <= 1'b0;
    cfg_bus.index            <= thp_pkg::CFG_PROP_GAIN;
    cfg_bus.data             <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 25; i++)
      send_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].res);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: program_regs(thp_pkg::PROP_GAIN_RST, thp_pkg::INTEG_GAIN_RST,
                        thp_pkg::DERIV_GAIN_RST, thp_pkg::INTEGRAL_LIMIT_RST,
                        thp_pkg::SETTLE_BAND_RST, thp_pkg::SETTLE_TICKS_RST,
                        thp_pkg::DRIVE_LIMIT_RST);
        1: program_regs(0, 0, 0, 0, 0, 1, 0);
        2: program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1000000, 18000, 255, 12000);
        default: program_regs(rand_gain(), rand_gain(), rand_gain(),
                              int'($urandom_range(0, 1000000) >> $urandom_range(0, 10)),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18000)
                                                          : $urandom_range(0, 400),
                              $urandom_range(0, 20), $urandom_range(0, 12000));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      if (ph == 4) begin
        // Hold the result side off while commands keep coming, so the input stalls.
        run_moves(PHASE_ITEMS / 2);
        hold_requests++;
        run_moves(PHASE_ITEMS / 2);
      end else begin
        run_moves(PHASE_ITEMS);
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_drives.size() == 0) begin
      $display("PASS turn_heading_pid_core");
    end else begin
      $display("FAIL turn_heading_pid_core");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/thp_pkg.sv
sv/thp_cmd_if.sv
sv/thp_rsp_if.sv
sv/thp_cfg_if.sv
sv/thp_drive_pipe.sv
sv/turn_heading_pid_core.sv
tb/tb_top.sv
